@@ rtl/ilbm_pkg.sv @@
// ----------------------------------------------------------------------------
// ilbm_pkg
// Shared types and constants for the interval liftover block map.
// ----------------------------------------------------------------------------
package ilbm_pkg;

  localparam int COORD_BITS = 36;
  localparam int IDX_BITS   = 12;
  localparam int MAX_BLOCKS = 1 << IDX_BITS;
  localparam int CFG_BITS   = 13;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [IDX_BITS-1:0]   entry_index;
    logic [COORD_BITS-1:0] old_start;
    logic [COORD_BITS-1:0] block_length;
    logic [COORD_BITS-1:0] new_start;
    logic [COORD_BITS-1:0] interval_start;
    logic [COORD_BITS-1:0] interval_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] mapped_start;
    logic [COORD_BITS-1:0] mapped_end;
    logic                  keep;
    logic                  out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] old_start;
    logic [COORD_BITS-1:0] block_length;
    logic [COORD_BITS-1:0] new_start;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_ent;     // write table entry from input item
    logic cap_map;    // capture interval, point index at last block
    logic mem_rd;     // read table at index
    logic ld_ent;     // latch read data as working entry
    logic idx_dec;
    logic idx_inc;
    logic start_sub;  // diff = start - entry old start
    logic ms_tr;      // mapped start = entry new start + diff
    logic ms_rd;      // mapped start = read data new start
    logic walk_sub;   // ge/diff of end against entry
    logic me_tr;      // mapped end = entry new start + diff
    logic me_prev;    // mapped end = last new coord of entry
    logic me_zero;    // end before first block
    logic set_oor;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_ge;       // read entry old start <= interval start
    logic idx_zero;
    logic idx_lt_last;
    logic start_in;    // start lies inside working entry
    logic walk_go;     // end_ge and end minus old start exceeds length
    logic end_ge;      // end at or above working entry old start
  } dp_sts_t;

endpackage

@@ rtl/ilbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ilbm_ctrl
// Sequencer for load, start scan, end walk and result hand-off.
// ----------------------------------------------------------------------------
module ilbm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  input  logic              out_stall,
  input  ilbm_pkg::dp_sts_t sts,
  output ilbm_pkg::dp_cmd_t cmd,
  output logic              in_stall,
  output logic              out_valid,
  output logic              cfg_ready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_START_SUB,
    ST_START_CHK,
    ST_NEXT_RD,
    ST_NEXT_EV,
    ST_WALK_SUB,
    ST_WALK_CHK,
    ST_WALK_RD,
    ST_WALK_LD,
    ST_END_FIN,
    ST_PREV_RD,
    ST_PREV_LD,
    ST_PREV_ADD,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   cfg_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall_r) begin
          if (in_command == ilbm_pkg::CMD_MAP) begin
            cmd.cap_map = 1'b1;
            state_nxt   = ST_SCAN_RD;
          end else begin
            cmd.wr_ent = 1'b1;
          end
        end
      end
      ST_SCAN_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        cmd.ld_ent = 1'b1;
        if (sts.rd_ge) begin
          state_nxt = ST_START_SUB;
        end else if (sts.idx_zero) begin
          // no block at or below start: first block's new start
          cmd.ms_rd = 1'b1;
          state_nxt = ST_WALK_SUB;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end
      end
      ST_START_SUB: begin
        cmd.start_sub = 1'b1;
        state_nxt     = ST_START_CHK;
      end
      ST_START_CHK: begin
        if (sts.start_in) begin
          cmd.ms_tr = 1'b1;
          state_nxt = ST_WALK_SUB;
        end else if (sts.idx_lt_last) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_NEXT_RD;
        end else begin
          cmd.set_oor = 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_NEXT_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_NEXT_EV;
      end
      ST_NEXT_EV: begin
        cmd.ms_rd   = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt   = ST_WALK_SUB;
      end
      ST_WALK_SUB: begin
        cmd.walk_sub = 1'b1;
        state_nxt    = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (sts.walk_go && sts.idx_lt_last) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_WALK_RD;
        end else begin
          state_nxt = ST_END_FIN;
        end
      end
      ST_WALK_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_WALK_LD;
      end
      ST_WALK_LD: begin
        cmd.ld_ent = 1'b1;
        state_nxt  = ST_WALK_SUB;
      end
      ST_END_FIN: begin
        if (sts.end_ge) begin
          cmd.me_tr = 1'b1;
          state_nxt = ST_OUT;
        end else if (!sts.idx_zero) begin
          cmd.idx_dec = 1'b1;
          state_nxt   = ST_PREV_RD;
        end else begin
          cmd.me_zero = 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_PREV_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_PREV_LD;
      end
      ST_PREV_LD: begin
        cmd.ld_ent = 1'b1;
        state_nxt  = ST_PREV_ADD;
      end
      ST_PREV_ADD: begin
        cmd.me_prev = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
    in_stall_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
      cfg_ready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_ready_r <= 1'b1;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;
  assign cfg_ready = cfg_ready_r;

endmodule

@@ rtl/ilbm_dpath.sv @@
// ----------------------------------------------------------------------------
// ilbm_dpath
// Block table, working entry, coordinate arithmetic and result register.
// ----------------------------------------------------------------------------
module ilbm_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ilbm_pkg::in_item_t                 in_item,
  input  logic                               cfg_we,
  input  logic [ilbm_pkg::CFG_BITS-1:0]      cfg_data,
  input  ilbm_pkg::dp_cmd_t                  cmd,
  output ilbm_pkg::dp_sts_t                  sts,
  output ilbm_pkg::out_item_t                out_item
);

  ilbm_pkg::entry_t                    mem [ilbm_pkg::MAX_BLOCKS];
  ilbm_pkg::entry_t                    rdata_r;
  ilbm_pkg::entry_t                    ent_r;
  ilbm_pkg::entry_t                    wr_ent;
  logic [ilbm_pkg::IDX_BITS-1:0]       last_r;
  logic [ilbm_pkg::IDX_BITS-1:0]       idx_r;
  logic [ilbm_pkg::COORD_BITS-1:0]     s_r, e_r, diff_r, ms_r, me_r;
  logic                                ge_r, end_ok_r, oor_r;
  ilbm_pkg::out_item_t                 out_r;

  assign wr_ent.old_start    = in_item.old_start;
  assign wr_ent.block_length = in_item.block_length;
  assign wr_ent.new_start    = in_item.new_start;

  // table, one port each way
  always_ff @(posedge clk) begin
    if (cmd.wr_ent) begin
      mem[in_item.entry_index] <= wr_ent;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[idx_r];
    end
  end

  // last used index: count 0 acts as 1, large counts saturate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (cfg_we) begin
      if (cfg_data == '0) begin
        last_r <= '0;
      end else if (32'(cfg_data) > ilbm_pkg::MAX_BLOCKS) begin
        last_r <= ilbm_pkg::IDX_BITS'(ilbm_pkg::MAX_BLOCKS - 1);
      end else begin
        last_r <= ilbm_pkg::IDX_BITS'(cfg_data - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_map) begin
      s_r      <= in_item.interval_start;
      e_r      <= in_item.interval_end;
      idx_r    <= last_r;
      end_ok_r <= 1'b1;
      oor_r    <= 1'b0;
    end
    if (cmd.idx_dec) idx_r <= idx_r - 1'b1;
    if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    if (cmd.ld_ent) ent_r <= rdata_r;
    if (cmd.start_sub) diff_r <= s_r - ent_r.old_start;
    if (cmd.walk_sub) begin
      ge_r   <= (e_r >= ent_r.old_start);
      diff_r <= e_r - ent_r.old_start;
    end
    if (cmd.ms_tr) ms_r <= ent_r.new_start + diff_r;
    if (cmd.ms_rd) ms_r <= rdata_r.new_start;
    if (cmd.me_tr) me_r <= ent_r.new_start + diff_r;
    if (cmd.me_prev) me_r <= ent_r.new_start + ent_r.block_length - 1'b1;
    if (cmd.me_zero) begin
      me_r     <= '0;
      end_ok_r <= 1'b0;
    end
    if (cmd.set_oor) oor_r <= 1'b1;
    if (cmd.out_load) begin
      if (oor_r) begin
        out_r.mapped_start <= '0;
        out_r.mapped_end   <= '0;
        out_r.keep         <= 1'b0;
        out_r.out_of_range <= 1'b1;
      end else begin
        out_r.mapped_start <= ms_r;
        out_r.mapped_end   <= me_r;
        out_r.keep         <= end_ok_r && (ms_r <= me_r);
        out_r.out_of_range <= 1'b0;
      end
    end
  end

  assign sts.rd_ge       = (rdata_r.old_start <= s_r);
  assign sts.idx_zero    = (idx_r == '0);
  assign sts.idx_lt_last = (idx_r < last_r);
  assign sts.start_in    = (diff_r < ent_r.block_length);
  assign sts.walk_go     = ge_r && (diff_r > ent_r.block_length);
  assign sts.end_ge      = ge_r;

  assign out_item = out_r;

endmodule

@@ rtl/interval_liftover_block_map.sv @@
// ----------------------------------------------------------------------------
// interval_liftover_block_map
// Lifts intervals from old to new coordinates over a loaded block chain.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  in_      | in_valid / in_stall  | in_item  (load entry or map interval)
//  out_     | out_valid / out_stall| out_item (one per map item)
//  cfg_     | cfg_valid / cfg_ready| cfg_data (block_count)
//
//  Load item: written in the cycle it is accepted, next item taken at once.
//  Map item (start block i, end block j): the table has one read port, so
//  the backward start scan reads one entry at a time from the last used
//  block, and the end walk steps one block at a time up to j. The next item
//  can be taken in the cycle the result appears. A stalled result holds the
//  block only once the next map item is done; synchronous reset clears
//  control, sets block_count to 1, table undefined.
//
module interval_liftover_block_map (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ilbm_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ilbm_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ilbm_pkg::CFG_BITS-1:0]  cfg_data
);

  ilbm_pkg::dp_cmd_t cmd;
  ilbm_pkg::dp_sts_t sts;
  logic              cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  // sequencer: scan, walk, hand-off
  ilbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_item.command),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .cfg_ready  (cfg_ready)
  );

  // table and arithmetic
  ilbm_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // an accepted map item makes the block busy, raising in_stall
  a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.command == ilbm_pkg::CMD_MAP) |=> in_stall)
    else $error("map item accepted without going busy");

  // loads complete in the accepting cycle
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.command == ilbm_pkg::CMD_LOAD) |=> !in_stall)
    else $error("load item left block busy");

  // out-of-range results carry zero coordinates and are never kept
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_of_range) |->
      (out_item.mapped_start == '0 && out_item.mapped_end == '0 && !out_item.keep))
    else $error("out-of-range result with nonzero fields");

  // a new result only appears at the end of a map item
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while idle");

endmodule
